// ===== src/bcrtc_pkg.sv =====
// Shared types, register codes and BCD calendar functions for the RTC block.
// Standalone package; used by bcrtc_core and the top level.
package bcrtc_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [3:0] REG_SEC      = 4'd0;
  localparam logic [3:0] REG_MIN      = 4'd1;
  localparam logic [3:0] REG_HOUR     = 4'd2;
  localparam logic [3:0] REG_WEEK     = 4'd3;
  localparam logic [3:0] REG_DAY      = 4'd4;
  localparam logic [3:0] REG_MON      = 4'd5;
  localparam logic [3:0] REG_YEAR     = 4'd6;
  localparam logic [3:0] REG_CTRL     = 4'd7;
  localparam logic [3:0] REG_AL0_MIN  = 4'd8;
  localparam logic [3:0] REG_AL0_HOUR = 4'd9;
  localparam logic [3:0] REG_AL0_WEEK = 4'd10;
  localparam logic [3:0] REG_AL1_MIN  = 4'd11;
  localparam logic [3:0] REG_AL1_HOUR = 4'd12;
  localparam logic [3:0] REG_AL1_DAY  = 4'd13;
  localparam logic [3:0] REG_AL1_MON  = 4'd14;

  localparam logic [1:0] IRQ_OFF = 2'd0;
  localparam logic [1:0] IRQ_2HZ = 2'd1;
  localparam logic [1:0] IRQ_1HZ = 2'd2;
  localparam logic [1:0] IRQ_MIN = 2'd3;

  localparam logic [7:0] MONTH_LEN [12] = '{8'h31, 8'h28, 8'h31, 8'h30, 8'h31, 8'h30,
                                             8'h31, 8'h31, 8'h30, 8'h31, 8'h30, 8'h31};

  typedef struct packed {
    logic [6:0] sec;
    logic [6:0] min;
    logic [5:0] hour;
    logic [2:0] week;
    logic [5:0] day;
    logic [4:0] mon;
    logic [7:0] year;
  } rtc_time_t;

  typedef struct packed {
    rtc_time_t tm;
    logic      carry;
  } rtc_adv_t;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] reg_addr;
    logic [7:0] write_data;
    logic       pulse_half_second;
    logic       pulse_one_second;
  } rtc_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       clock_irq;
    logic       alarm0_irq;
    logic       alarm1_irq;
  } rtc_result_t;

  function automatic logic [7:0] fix_digit(logic [7:0] v);
    fix_digit = (v[3:0] > 4'd9) ? {v[7:4] + 4'd1, 4'd0} : v;
  endfunction

  function automatic logic [8:0] bcd_inc(logic [7:0] v);
    logic [8:0] t;
    t = {1'b0, v} + 9'd1;
    if (t[3:0] > 4'd9) begin
      t = t + 9'd6;
    end
    return t;
  endfunction

  function automatic logic month_valid(logic [7:0] m);
    return (m != 8'h00) && (m <= 8'h12) && (m[3:0] <= 4'd9);
  endfunction

  function automatic logic [7:0] month_length(logic [4:0] m, logic [7:0] y);
    logic [4:0] dm;
    logic [1:0] lsum;
    logic       leap;
    logic [3:0] idx;
    dm   = (m[4] ? 5'd10 : 5'd0) + {1'b0, m[3:0]};
    lsum = {y[4], 1'b0} + y[1:0];
    leap = (lsum == 2'd0);
    idx  = 4'(dm - 5'd1);
    if (dm == 5'd0 || dm > 5'd12) begin
      return 8'h31;
    end else if (dm == 5'd2) begin
      return leap ? 8'h29 : 8'h28;
    end
    return MONTH_LEN[idx];
  endfunction

  function automatic rtc_time_t normalize(rtc_time_t t);
    logic [7:0] s, mi, h, d, mo, y, lim;
    logic [2:0] w;
    logic       mv;
    rtc_time_t  r;
    s  = {1'b0, t.sec};
    mi = {1'b0, t.min};
    h  = {2'b0, t.hour};
    d  = {2'b0, t.day};
    mo = {3'b0, t.mon};
    y  = t.year;
    w  = t.week;
    s = fix_digit(s);
    if (s >= 8'h60) begin
      s = 8'h00;
      if (mi[3:0] <= 4'd9) mi = mi + 8'd1;
    end
    mi = fix_digit(mi);
    if (mi >= 8'h60) begin
      mi = 8'h00;
      if (h[3:0] <= 4'd9) h = h + 8'd1;
    end
    h = fix_digit(h);
    if (h >= 8'h24) begin
      h = 8'h00;
      w = (w == 3'd7) ? 3'd1 : w + 3'd1;
      if (d[3:0] <= 4'd9) d = d + 8'd1;
    end
    mv  = month_valid(mo);
    lim = mv ? month_length(mo[4:0], y) : 8'h31;
    if (d == 8'h00) d = 8'h01;
    d = fix_digit(d);
    if (d > lim) begin
      d = 8'h01;
      if (mv) mo = mo + 8'd1;
    end
    if (mo == 8'h00) mo = 8'h01;
    mo = fix_digit(mo);
    if (mo > 8'h12) begin
      mo = 8'h01;
      if (y[3:0] <= 4'd9 && y < 8'hA0) y = y + 8'd1;
    end
    y = fix_digit(y);
    if (y >= 8'hA0) y = 8'h00;
    r.sec  = s[6:0];
    r.min  = mi[6:0];
    r.hour = h[5:0];
    r.week = w;
    r.day  = d[5:0];
    r.mon  = mo[4:0];
    r.year = y;
    return r;
  endfunction

  function automatic rtc_adv_t advance(rtc_time_t t);
    logic [8:0] v;
    rtc_adv_t   a;
    a.tm    = t;
    a.carry = 1'b0;
    v = bcd_inc({1'b0, t.sec});
    if (v < 9'h060) begin
      a.tm.sec = v[6:0];
    end else begin
      a.tm.sec = 7'h00;
      a.carry  = 1'b1;
      v = bcd_inc({1'b0, t.min});
      if (v < 9'h060) begin
        a.tm.min = v[6:0];
      end else begin
        a.tm.min = 7'h00;
        v = bcd_inc({2'b0, t.hour});
        if (v < 9'h024) begin
          a.tm.hour = v[5:0];
        end else begin
          a.tm.hour = 6'h00;
          a.tm.week = (t.week == 3'd7) ? 3'd1 : t.week + 3'd1;
          v = bcd_inc({2'b0, t.day});
          a.tm.day = v[5:0];
          if ({2'b0, a.tm.day} > month_length(t.mon, t.year)) begin
            a.tm.day = 6'h01;
            v = bcd_inc({3'b0, t.mon});
            if (v <= 9'h012) begin
              a.tm.mon = v[4:0];
            end else begin
              a.tm.mon = 5'h01;
              v = bcd_inc(t.year);
              a.tm.year = (v >= 9'h0A0) ? 8'h00 : v[7:0];
            end
          end
        end
      end
    end
    return a;
  endfunction

endpackage

// ===== src/bcd_calendar_rtc_with_alarms_unit.sv =====
// BCD real-time clock and calendar with two alarms, stream interface.
// Depends on bcrtc_pkg and bcrtc_core.
//
// Usage: each request on the slave stream is a register read, a register
// write or a time-base tick (op in s_tuser). Every request gives exactly one
// response on the master stream: read data on a read, and the periodic and
// alarm interrupt flags on a tick; other fields are zero.
// Path: a request accepted from the slave stream is held in the input
// register, processed against the register file, and its response is
// captured in the output register, from which it is valid on m_tdata.
// Throughput: one request per cycle while m_tready is high; the calendar carry
// chain and the alarm compare settle between the input and output registers.
// Reset: all time fields clear, weekday becomes 1, the clock is stopped with
// no periodic interrupt, both alarms clear, and both streams go empty.
// Stall: while m_tready is low a response holds in the output register; one
// more request still waits in the input register before s_tready drops.
module bcd_calendar_rtc_with_alarms_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [3:0] reg_addr, [11:4] write_data, [12] pulse_half_second,
  // [13] pulse_one_second, [15:14] zero
  input  logic [15:0] s_tdata,
  // [1:0] op
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] read_data, [8] clock_irq, [9] alarm0_irq, [10] alarm1_irq,
  // [15:11] zero
  output logic [15:0] m_tdata
);
  import bcrtc_pkg::*;

  logic        in_valid;
  rtc_item_t   in_item;
  logic        take;
  rtc_result_t core_res;
  rtc_result_t out_res;

  assign take     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.op                <= s_tuser;
      in_item.reg_addr          <= s_tdata[3:0];
      in_item.write_data        <= s_tdata[11:4];
      in_item.pulse_half_second <= s_tdata[12];
      in_item.pulse_one_second  <= s_tdata[13];
    end
  end

  bcrtc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .item (in_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= core_res;
    end
  end

  assign m_tdata = {5'b0, out_res.alarm1_irq, out_res.alarm0_irq, out_res.clock_irq,
                    out_res.read_data};

endmodule

// ===== src/bcrtc_core.sv =====
// Register file, calendar update and alarm compare for the RTC block.
// Depends on bcrtc_pkg; processes one request per cycle when step is high.
module bcrtc_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  bcrtc_pkg::rtc_item_t item,
  output bcrtc_pkg::rtc_result_t res
);
  import bcrtc_pkg::*;

  rtc_time_t   tm, tm_next;
  logic [2:0]  ctrl, ctrl_next;
  logic [15:0] al0, al0_next;
  logic [23:0] al1, al1_next;
  rtc_adv_t    adv;
  logic [7:0]  rd;
  logic [1:0]  mode;
  logic        time_lock;

  assign adv       = advance(tm);
  assign mode      = ctrl[2:1];
  assign time_lock = (item.reg_addr <= REG_YEAR) && ctrl[0];

  always_comb begin
    unique case (item.reg_addr)
      REG_SEC:      rd = {1'b0, tm.sec};
      REG_MIN:      rd = {1'b0, tm.min};
      REG_HOUR:     rd = {2'b0, tm.hour};
      REG_WEEK:     rd = {5'b0, tm.week};
      REG_DAY:      rd = {2'b0, tm.day};
      REG_MON:      rd = {3'b0, tm.mon};
      REG_YEAR:     rd = tm.year;
      REG_CTRL:     rd = {5'b0, ctrl};
      REG_AL0_MIN:  rd = {1'b0, al0[6:0]};
      REG_AL0_HOUR: rd = {2'b0, al0[12:7]};
      REG_AL0_WEEK: rd = {5'b0, al0[15:13]};
      REG_AL1_MIN:  rd = {1'b0, al1[6:0]};
      REG_AL1_HOUR: rd = {2'b0, al1[12:7]};
      REG_AL1_DAY:  rd = {2'b0, al1[18:13]};
      REG_AL1_MON:  rd = {3'b0, al1[23:19]};
      default:      rd = 8'h00;
    endcase
  end

  always_comb begin
    tm_next   = tm;
    ctrl_next = ctrl;
    al0_next  = al0;
    al1_next  = al1;
    res       = '0;
    case (item.op)
      OP_READ: begin
        res.read_data = rd;
      end
      OP_WRITE: begin
        if (!time_lock) begin
          unique case (item.reg_addr)
            REG_SEC:      tm_next.sec  = item.write_data[6:0];
            REG_MIN:      tm_next.min  = item.write_data[6:0];
            REG_HOUR:     tm_next.hour = item.write_data[5:0];
            REG_WEEK:     tm_next.week = (item.write_data[2:0] != 3'd0) ?
                                         item.write_data[2:0] : 3'd7;
            REG_DAY:      tm_next.day  = item.write_data[5:0];
            REG_MON:      tm_next.mon  = item.write_data[4:0];
            REG_YEAR:     tm_next.year = item.write_data;
            REG_CTRL: begin
              ctrl_next = item.write_data[2:0];
              if (item.write_data[0]) begin
                tm_next = normalize(tm);
              end
            end
            REG_AL0_MIN:  al0_next[6:0]   = item.write_data[6:0];
            REG_AL0_HOUR: al0_next[12:7]  = item.write_data[5:0];
            REG_AL0_WEEK: al0_next[15:13] = item.write_data[2:0];
            REG_AL1_MIN:  al1_next[6:0]   = item.write_data[6:0];
            REG_AL1_HOUR: al1_next[12:7]  = item.write_data[5:0];
            REG_AL1_DAY:  al1_next[18:13] = item.write_data[5:0];
            REG_AL1_MON:  al1_next[23:19] = item.write_data[4:0];
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        if (item.pulse_half_second && mode == IRQ_2HZ) begin
          res.clock_irq = 1'b1;
        end
        if (item.pulse_one_second) begin
          if (mode == IRQ_1HZ) begin
            res.clock_irq = 1'b1;
          end
          if (ctrl[0]) begin
            tm_next = adv.tm;
            if (adv.carry) begin
              if (mode == IRQ_MIN) begin
                res.clock_irq = 1'b1;
              end
              res.alarm0_irq = (adv.tm.min == al0[6:0]) && (adv.tm.hour == al0[12:7]) &&
                               (al0[15:13] == 3'd0 || al0[15:13] == adv.tm.week);
              res.alarm1_irq = (adv.tm.min == al1[6:0]) && (adv.tm.hour == al1[12:7]) &&
                               (al1[18:13] == 6'd0 || al1[18:13] == adv.tm.day) &&
                               (al1[23:19] == 5'd0 || al1[23:19] == adv.tm.mon);
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tm   <= '{sec: 7'h00, min: 7'h00, hour: 6'h00, week: 3'd1, day: 6'h00,
                mon: 5'h00, year: 8'h00};
      ctrl <= '0;
      al0  <= '0;
      al1  <= '0;
    end else if (step) begin
      tm   <= tm_next;
      ctrl <= ctrl_next;
      al0  <= al0_next;
      al1  <= al1_next;
    end
  end

  a_week_nonzero: assert property (@(posedge clk) disable iff (rst)
    tm.week != 3'd0)
    else $error("weekday holds zero");

  a_run_month_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl[0] |-> (tm.mon != 5'd0 && tm.mon <= 5'h12 && tm.mon[3:0] <= 4'd9 &&
                 tm.sec < 7'h60 && tm.min < 7'h60))
    else $error("running clock holds an invalid field");

  a_read_only_on_read: assert property (@(posedge clk) disable iff (rst)
    (step && item.op != OP_READ) |-> res.read_data == 8'h00)
    else $error("read data driven on a non-read request");

  a_alarm_needs_tick: assert property (@(posedge clk) disable iff (rst)
    (step && !(item.op == OP_TICK && item.pulse_one_second && ctrl[0])) |->
      (!res.alarm0_irq && !res.alarm1_irq))
    else $error("alarm raised without a running second tick");

endmodule
